/* rtl/bounded_deque_with_value_removal_macros.svh */
// Assertion macros for the bounded deque block.
// Used by the top level only; no other dependencies.
`ifndef BOUNDED_DEQUE_WITH_VALUE_REMOVAL_MACROS_SVH
`define BOUNDED_DEQUE_WITH_VALUE_REMOVAL_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define BDQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdq assertion failed");

// Next-cycle implication, disabled while reset is held
`define BDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdq assertion failed");

`endif

/* rtl/bdq_pkg.sv */
// Shared constants, types and helper functions for the bounded deque.
// No dependencies; the interface, controller, datapath and top files refer to it by scoped names.
`default_nettype none

package bdq_pkg;

    // Storage geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Fixed transaction field widths
    localparam int REQ_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 4;
    localparam int READ_W    = 32;
    localparam int ENTRY_W   = 5;
    localparam int STATUS_W  = 2;
    localparam int REMOVED_W = 5;

    typedef logic [PTR_W-1:0]      t_ptr;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [CNT_W:0]        t_sum;
    typedef logic [DATA_WIDTH-1:0] t_word;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ       = 3'd4;
    localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic start;   // latch request, issue first store read
        logic exec;    // complete a push, pop or read
        logic walk;    // handle one entry of a remove sweep
        logic finish;  // close a remove sweep
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic new_is_remove;
        logic walk_done;
    } t_stat;

    // Ring slot at an offset from the front (offset at most the depth)
    function automatic t_ptr slot_of(input t_ptr front, input t_cnt off);
        t_sum sum;
        sum = t_sum'(front) + t_sum'(off);
        if (sum >= t_sum'(DEPTH)) begin
            sum = sum - t_sum'(DEPTH);
        end
        return t_ptr'(sum);
    endfunction

    // Ring slot before the given one
    function automatic t_ptr ptr_dec(input t_ptr p);
        t_ptr r;
        if (p == '0) begin
            r = t_ptr'(DEPTH - 1);
        end else begin
            r = p - t_ptr'(1);
        end
        return r;
    endfunction

    // Input word reduced to the stored width
    function automatic t_word to_word(input logic [VALUE_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[DATA_WIDTH-1:0];
    endfunction

    // Stored word to the read data width
    function automatic logic [READ_W-1:0] to_read(input t_word d);
        logic [63:0] w;
        w = 64'(d);
        return w[READ_W-1:0];
    endfunction

    // Count to the output count width
    function automatic logic [ENTRY_W-1:0] to_count(input t_cnt c);
        logic [31:0] w;
        w = 32'(c);
        return w[ENTRY_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/bdq_if.sv */
// Request and response channel interfaces for the bounded deque.
// Depends on bdq_pkg for field widths.
`default_nettype none

// Request channel
interface bdq_req_if;
    logic                          valid;
    logic                          ready;
    logic [bdq_pkg::REQ_W-1:0]     req_type;
    logic [bdq_pkg::VALUE_W-1:0]   item_value;
    logic [bdq_pkg::POS_W-1:0]     position;

    modport source (output valid, req_type, item_value, position, input ready);
    modport sink   (input valid, req_type, item_value, position, output ready);
endinterface

// Response channel
interface bdq_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bdq_pkg::READ_W-1:0]      read_data;
    logic [bdq_pkg::ENTRY_W-1:0]     entry_count;
    logic [bdq_pkg::STATUS_W-1:0]    status;
    logic [bdq_pkg::REMOVED_W-1:0]   removed_count;

    modport source (output valid, read_data, entry_count, status, removed_count,
                    input ready);
    modport sink   (input valid, read_data, entry_count, status, removed_count,
                    output ready);
endinterface

`default_nettype wire

/* rtl/bdq_ctrl.sv */
// Sequencing state machine for the bounded deque.
// Depends on bdq_pkg for command and status structs.
`default_nettype none

module bdq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_out_ready,
    input  wire bdq_pkg::t_stat i_stat,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output bdq_pkg::t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_WALK = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    // Take a transaction only when the result register will be free
    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_stat.new_is_remove ? ST_WALK : ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_WALK: begin
                if (i_stat.walk_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        if (o_cmd.exec || o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* rtl/bdq_dp.sv */
// Datapath of the bounded deque: ring store, pointers, sweep counters, result.
// Depends on bdq_pkg for widths, codes and slot arithmetic.
`default_nettype none

module bdq_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bdq_pkg::t_cmd                   i_cmd,
    output bdq_pkg::t_stat                       o_stat,
    input  wire logic [bdq_pkg::REQ_W-1:0]       i_req_type,
    input  wire logic [bdq_pkg::VALUE_W-1:0]     i_item_value,
    input  wire logic [bdq_pkg::POS_W-1:0]       i_position,
    output logic      [bdq_pkg::READ_W-1:0]      o_read_data,
    output logic      [bdq_pkg::ENTRY_W-1:0]     o_entry_count,
    output logic      [bdq_pkg::STATUS_W-1:0]    o_status,
    output logic      [bdq_pkg::REMOVED_W-1:0]   o_removed_count
);

    // Ring store, one write and one registered read port
    bdq_pkg::t_word mem [bdq_pkg::DEPTH];
    bdq_pkg::t_word r_rdata;

    // Queue state
    bdq_pkg::t_ptr r_front, n_front;
    bdq_pkg::t_cnt r_occ, n_occ;

    // Latched request and sweep counters
    logic [bdq_pkg::REQ_W-1:0] r_req;
    bdq_pkg::t_word            r_word;
    logic [bdq_pkg::POS_W-1:0] r_pos;
    bdq_pkg::t_cnt             r_k, r_kept, r_removed;
    bdq_pkg::t_cnt             n_kept, n_removed;

    // Result registers
    logic [bdq_pkg::READ_W-1:0]    r_o_data;
    logic [bdq_pkg::ENTRY_W-1:0]   r_o_count;
    logic [bdq_pkg::STATUS_W-1:0]  r_o_status;
    logic [bdq_pkg::REMOVED_W-1:0] r_o_removed;

    // Store port signals and result values
    logic                          w_re, w_we;
    bdq_pkg::t_ptr                 w_raddr, w_waddr;
    bdq_pkg::t_word                w_wdata, w_res_data;
    bdq_pkg::t_cnt                 w_start_off;
    logic [bdq_pkg::STATUS_W-1:0]  w_res_status;
    logic                          w_full, w_empty;

    assign w_full  = (r_occ == bdq_pkg::t_cnt'(bdq_pkg::DEPTH));
    assign w_empty = (r_occ == '0);

    assign o_stat.new_is_remove = (i_req_type == bdq_pkg::REQ_REMOVE);
    assign o_stat.walk_done     = (r_k == r_occ);

    // First read offset, chosen from the incoming request
    always_comb begin
        case (i_req_type)
            bdq_pkg::REQ_POP_BACK: w_start_off = r_occ - bdq_pkg::t_cnt'(1);
            bdq_pkg::REQ_READ:     w_start_off = bdq_pkg::t_cnt'(i_position);
            default:               w_start_off = '0;
        endcase
    end

    // Read address: at acceptance, or the next entry of a sweep
    assign w_re    = i_cmd.start || i_cmd.walk;
    assign w_raddr = i_cmd.walk
                   ? bdq_pkg::slot_of(r_front, r_k + bdq_pkg::t_cnt'(1))
                   : bdq_pkg::slot_of(r_front, w_start_off);

    // Operation logic
    always_comb begin
        n_front      = r_front;
        n_occ        = r_occ;
        n_kept       = r_kept;
        n_removed    = r_removed;
        w_we         = 1'b0;
        w_waddr      = bdq_pkg::slot_of(r_front, r_kept);
        w_wdata      = r_word;
        w_res_data   = '0;
        w_res_status = bdq_pkg::STAT_OK;
        if (i_cmd.exec) begin
            case (r_req)
                bdq_pkg::REQ_PUSH_FRONT: begin
                    if (w_full) begin
                        w_res_status = bdq_pkg::STAT_FULL;
                    end else begin
                        n_front = bdq_pkg::ptr_dec(r_front);
                        w_we    = 1'b1;
                        w_waddr = bdq_pkg::ptr_dec(r_front);
                        n_occ   = r_occ + bdq_pkg::t_cnt'(1);
                    end
                end
                bdq_pkg::REQ_PUSH_BACK: begin
                    if (w_full) begin
                        w_res_status = bdq_pkg::STAT_FULL;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = bdq_pkg::slot_of(r_front, r_occ);
                        n_occ   = r_occ + bdq_pkg::t_cnt'(1);
                    end
                end
                bdq_pkg::REQ_POP_FRONT: begin
                    if (w_empty) begin
                        w_res_status = bdq_pkg::STAT_EMPTY;
                    end else begin
                        w_res_data = r_rdata;
                        n_front    = bdq_pkg::slot_of(r_front, bdq_pkg::t_cnt'(1));
                        n_occ      = r_occ - bdq_pkg::t_cnt'(1);
                    end
                end
                bdq_pkg::REQ_POP_BACK: begin
                    if (w_empty) begin
                        w_res_status = bdq_pkg::STAT_EMPTY;
                    end else begin
                        w_res_data = r_rdata;
                        n_occ      = r_occ - bdq_pkg::t_cnt'(1);
                    end
                end
                bdq_pkg::REQ_READ: begin
                    if (32'(r_pos) >= 32'(r_occ)) begin
                        w_res_status = bdq_pkg::STAT_RANGE;
                    end else begin
                        w_res_data = r_rdata;
                    end
                end
                default: begin
                    w_res_status = bdq_pkg::STAT_OK;
                end
            endcase
        end else if (i_cmd.walk) begin
            // Drop a match, otherwise move the entry down to the kept slot
            if (r_rdata == r_word) begin
                n_removed = r_removed + bdq_pkg::t_cnt'(1);
            end else begin
                w_we    = 1'b1;
                w_wdata = r_rdata;
                n_kept  = r_kept + bdq_pkg::t_cnt'(1);
            end
        end else if (i_cmd.finish) begin
            n_occ = r_kept;
        end
    end

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    // Queue state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_occ   <= '0;
        end else begin
            r_front <= n_front;
            r_occ   <= n_occ;
        end
    end

    // Request latch and sweep counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req     <= i_req_type;
            r_word    <= bdq_pkg::to_word(i_item_value);
            r_pos     <= i_position;
            r_k       <= '0;
            r_kept    <= '0;
            r_removed <= '0;
        end else if (i_cmd.walk) begin
            r_k       <= r_k + bdq_pkg::t_cnt'(1);
            r_kept    <= n_kept;
            r_removed <= n_removed;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec || i_cmd.finish) begin
            r_o_data    <= bdq_pkg::to_read(w_res_data);
            r_o_count   <= bdq_pkg::to_count(n_occ);
            r_o_status  <= w_res_status;
            r_o_removed <= i_cmd.finish ? bdq_pkg::to_count(r_removed) : '0;
        end
    end

    assign o_read_data     = r_o_data;
    assign o_entry_count   = r_o_count;
    assign o_status        = r_o_status;
    assign o_removed_count = r_o_removed;

endmodule

`default_nettype wire

/* rtl/bounded_deque_with_value_removal.sv */
// Bounded deque with value removal. A transaction is accepted in the idle state;
// push, pop and read pass through the execute state, which registers their result.
// Remove-by-value sweeps the live entries through the single store read port:
// the result is registered as the sweep closes; no new transaction is taken until idle.
// Synchronous active-low reset empties the queue (front and count to zero);
// the ring store is not cleared and needs no clearing pass.
`default_nettype none
`include "bounded_deque_with_value_removal_macros.svh"

module bounded_deque_with_value_removal (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bdq_req_if.sink   i_req,
    bdq_rsp_if.source o_rsp
);

    bdq_pkg::t_cmd  w_cmd;
    bdq_pkg::t_stat w_stat;
    logic           w_in_ready;
    logic           w_out_valid;
    logic           w_in_accept;

    // Sequencer
    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    // Store and result datapath
    bdq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_req_type      (i_req.req_type),
        .i_item_value    (i_req.item_value),
        .i_position      (i_req.position),
        .o_read_data     (o_rsp.read_data),
        .o_entry_count   (o_rsp.entry_count),
        .o_status        (o_rsp.status),
        .o_removed_count (o_rsp.removed_count)
    );

    assign i_req.ready = w_in_ready;
    assign o_rsp.valid = w_out_valid;
    assign w_in_accept = i_req.valid && w_in_ready;

    // One transaction in flight at a time
    `BDQ_ASSERT_NEXT(a_single_flight, i_clk, i_rst_n, w_in_accept, !i_req.ready)
    // Result register is drained before work on a new transaction begins
    `BDQ_ASSERT_NEXT(a_out_drained, i_clk, i_rst_n, w_in_accept, !o_rsp.valid)
    // Reported count never exceeds capacity
    `BDQ_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, o_rsp.valid,
        32'(o_rsp.entry_count) <= 32'(bdq_pkg::DEPTH))

endmodule

`default_nettype wire
